@@ src/point_cloud_to_scan_binner_assert.svh @@
// Assertion macros for the point cloud scan binner.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef POINT_CLOUD_TO_SCAN_BINNER_ASSERT_SVH
`define POINT_CLOUD_TO_SCAN_BINNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pcsb_pkg.sv @@
// Package for the point cloud scan binner: status codes, register indexes,
// controller states, fixed widths and the CORDIC arctangent table. No dependencies.
package pcsb_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int GUARD_SHIFT  = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int SEL_W        = 9;
    localparam int WIDTH_W      = 15;
    localparam int DIV_W        = 17;
    localparam int RANGE_W      = 16;
    localparam int LIM_W        = 33;
    localparam int SQRT_STEPS   = 17;
    localparam int CNT_W        = 5;
    localparam logic [16:0] EMPTY_OFFSET = 17'd1000;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_INVALID = 3'd1,
        ST_HEIGHT  = 3'd2,
        ST_ANGLE   = 3'd3,
        ST_READ    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_HEIGHT_LOW  = 3'd0,
        CFG_HEIGHT_HIGH = 3'd1,
        CFG_WIN_START   = 3'd2,
        CFG_WIN_END     = 3'd3,
        CFG_BIN_WIDTH   = 3'd4,
        CFG_FAR_LIMIT   = 3'd5
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_NBIN,
        S_CORDIC,
        S_IDX,
        S_RMW_RD,
        S_RMW_CMP,
        S_RD_RD,
        S_RD_CHK,
        S_SQRT,
        S_RESULT
    } t_state;

    // atan(2^-i) as a 32-bit binary angle where 2^31 is pi.
    function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] step);
        logic [31:0] v;
        unique case (step)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/pcsb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the bin store of the scan binner.
module pcsb_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/point_cloud_to_scan_binner.sv @@
// Top level of the point cloud scan binner: control, serial arithmetic units.
// Depends on pcsb_pkg, pcsb_ram and point_cloud_to_scan_binner_assert.svh.
//
// Usage. The input channel (i_in_valid / o_in_stall) carries one item per
// transfer: either a point to add or a request to read and clear one bin.
// The output channel (o_out_valid / i_out_stall) returns exactly one result
// per item, in order. Configuration registers are written through the plain
// write port (i_cfg_we, i_cfg_index, i_cfg_data) while the block is idle.
//
// Timing. One item is worked on at a time. Every item first runs the bin
// count through a 17-step restoring divider. A read item then reads the
// store and, for a filled bin, runs a 2-bit-per-step square root. A point
// that passes the height test runs a 28-step CORDIC (the squared range is
// formed bit-serially alongside) and, if its bearing lies in the window,
// the 17-step index division and a read-modify-write of its bin. Points
// rejected as invalid or by height finish after the first division. The
// serial divider, the CORDIC loop and the bin store's single write port
// set how long an item takes.
//
// Reset. After reset the block sweeps the bin store, one entry per cycle,
// over all MAX_BINS entries; o_in_stall stays high during the sweep.
// Configuration writes are taken during the sweep as at any other time.
//
// Backpressure. A finished result waits in the output register while the
// receiver stalls; the next item can already be accepted, and its result is
// held in the controller until the output register frees up.
`include "point_cloud_to_scan_binner_assert.svh"

module point_cloud_to_scan_binner import pcsb_pkg::*; #(
    parameter int MAX_BINS   = 512,
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic signed [COORD_BITS-1:0] i_coord_x_mm,
    input  logic signed [COORD_BITS-1:0] i_coord_y_mm,
    input  logic signed [COORD_BITS-1:0] i_coord_z_mm,
    input  logic                         i_point_ok,
    input  logic [SEL_W-1:0]             i_bin_select,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic [SEL_W-1:0]             o_bin_index,
    output logic [RANGE_W-1:0]           o_range_mm,
    output logic                         o_bin_empty
);

    localparam int AW     = $clog2(MAX_BINS);
    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int CW     = COORD_BITS + GUARD_SHIFT + 3;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SQC_W  = (SQ_W > LIM_W) ? SQ_W : LIM_W;
    localparam int YC_W   = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;
    localparam int AC_W   = ((ANGLE_BITS > CFG_W) ? ANGLE_BITS : CFG_W) + 1;
    localparam int ANG_SH = 32 - ANGLE_BITS;
    localparam int RW     = LIM_W + 1;

    // Configuration registers.
    logic signed [CFG_W-1:0] r_h_low, r_h_high, r_w_start, r_w_end;
    logic [WIDTH_W-1:0]      r_bin_w;
    logic [CFG_W-1:0]        r_far;
    logic [LIM_W-1:0]        r_lim;

    // Control.
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_clr_addr;
    logic             r_out_valid;

    // Item and working registers.
    logic                         r_op, r_ok, r_zero;
    logic [SEL_W-1:0]             r_sel;
    logic signed [COORD_BITS-1:0] r_y;
    logic signed [CW-1:0]         r_a, r_b;
    logic [31:0]                  r_ang;
    logic [SQ_W-1:0]              r_mx, r_mz, r_sq;
    logic [COORD_BITS-1:0]        r_bx, r_bz;
    logic [DIV_W-1:0]             r_dq;
    logic [WIDTH_W-1:0]           r_drem;
    logic [NB_W-1:0]              r_nbins;
    logic [AW-1:0]                r_idx;
    logic [2*SQRT_STEPS-1:0]      r_rad;
    logic [SQRT_STEPS-1:0]        r_root;
    logic [SQRT_STEPS+1:0]        r_rem;
    logic [2:0]                   r_res_status;
    logic [SEL_W-1:0]             r_res_idx;
    logic [RANGE_W-1:0]           r_res_range;
    logic                         r_res_empty;
    logic [2:0]                   r_out_status;
    logic [SEL_W-1:0]             r_out_idx;
    logic [RANGE_W-1:0]           r_out_range;
    logic                         r_out_empty;

    // RAM port signals.
    logic          ram_we, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [RW-1:0] ram_wr_data, ram_rd_data;

    // Derived values from configuration.
    logic [WIDTH_W-1:0]      w_eff;
    logic signed [CFG_W:0]   span;
    logic [DIV_W-1:0]        nb_num;
    logic [16:0]             far_ext;
    logic [33:0]             lim_prod;
    logic [RANGE_W-1:0]      empty_val;

    always_comb begin
        w_eff    = (r_bin_w == '0) ? WIDTH_W'(1) : r_bin_w;
        span     = (CFG_W+1)'(r_w_end) - (CFG_W+1)'(r_w_start);
        nb_num   = (span > 0) ? (DIV_W'(span) + DIV_W'(w_eff) - DIV_W'(1)) : '0;
        far_ext  = 17'(r_far) + EMPTY_OFFSET;
        lim_prod = 34'(far_ext) * 34'(far_ext);
        empty_val = far_ext[16] ? {RANGE_W{1'b1}} : far_ext[15:0];
    end

    // Input magnitudes for the bit-serial squares and CORDIC start vector.
    logic [COORD_BITS-1:0] x_abs, z_abs;
    logic signed [CW-1:0]  x_sc, z_sc;
    logic                  in_take;

    always_comb begin
        x_abs   = i_coord_x_mm[COORD_BITS-1] ? (~i_coord_x_mm + 1'b1) : i_coord_x_mm;
        z_abs   = i_coord_z_mm[COORD_BITS-1] ? (~i_coord_z_mm + 1'b1) : i_coord_z_mm;
        x_sc    = CW'(i_coord_x_mm) <<< GUARD_SHIFT;
        z_sc    = CW'(i_coord_z_mm) <<< GUARD_SHIFT;
        in_take = i_in_valid && !o_in_stall;
    end

    // Height test.
    logic signed [YC_W-1:0] y_c, lo_c, hi_c;
    logic                   height_bad;

    always_comb begin
        y_c        = YC_W'(r_y);
        lo_c       = YC_W'(r_h_low);
        hi_c       = YC_W'(r_h_high);
        height_bad = (y_c > hi_c) || (y_c < lo_c);
    end

    // One CORDIC rotation per cycle: vectoring toward the positive a axis.
    logic signed [CW-1:0] sh_a, sh_b;
    logic                 b_pos;
    logic [31:0]          atan_v;

    always_comb begin
        sh_a   = r_a >>> r_cnt;
        sh_b   = r_b >>> r_cnt;
        b_pos  = !r_b[CW-1] && (r_b != '0);
        atan_v = atan_entry(r_cnt);
    end

    // Bearing: negate, round half up to ANGLE_BITS, compare with the window.
    logic [31:0]             ang_neg, ang_rnd;
    logic [ANGLE_BITS-1:0]   ang_q;
    logic signed [AC_W-1:0]  ang_c, st_c, en_c, ang_diff;
    logic                    angle_bad;

    always_comb begin
        ang_neg   = 32'd0 - r_ang;
        ang_rnd   = ang_neg + (32'd1 << (ANG_SH - 1));
        ang_q     = r_zero ? '0 : ang_rnd[31:ANG_SH];
        ang_c     = AC_W'(signed'(ang_q));
        st_c      = AC_W'(r_w_start);
        en_c      = AC_W'(r_w_end);
        angle_bad = (ang_c < st_c) || (ang_c > en_c);
        ang_diff  = ang_c - st_c;
    end

    // Restoring divider step, one quotient bit per cycle.
    logic [WIDTH_W:0]   div_trial;
    logic               div_ge;
    logic [WIDTH_W-1:0] div_rem_n;

    always_comb begin
        div_trial = {r_drem, r_dq[DIV_W-1]};
        div_ge    = div_trial >= (WIDTH_W+1)'(w_eff);
        div_rem_n = div_ge ? WIDTH_W'(div_trial - (WIDTH_W+1)'(w_eff))
                           : WIDTH_W'(div_trial);
    end

    // Bin count and clamped bin index from the divider quotient.
    logic [DIV_W-1:0] nb_clamp, idx_q;
    logic [AW-1:0]    idx_next;
    logic [15:0]      idx_wide;

    always_comb begin
        if (r_dq == '0) begin
            nb_clamp = DIV_W'(1);
        end else if (r_dq > DIV_W'(MAX_BINS)) begin
            nb_clamp = DIV_W'(MAX_BINS);
        end else begin
            nb_clamp = r_dq;
        end
        idx_q    = (r_dq >= DIV_W'(r_nbins)) ? (DIV_W'(r_nbins) - DIV_W'(1)) : r_dq;
        idx_next = idx_q[AW-1:0];
        idx_wide = 16'(r_idx);
    end

    // Read item selection.
    logic [15:0]   sel_wide;
    logic          sel_in, sel_lt_nb, rd_has;
    logic [AW-1:0] sel_addr;

    always_comb begin
        sel_wide  = 16'(r_sel);
        sel_in    = sel_wide < 16'(MAX_BINS);
        sel_lt_nb = sel_wide < 16'(r_nbins);
        sel_addr  = sel_wide[AW-1:0];
        rd_has    = sel_in && sel_lt_nb && ram_rd_data[LIM_W];
    end

    // Bin update decision.
    logic [SQC_W-1:0] sq_c, lim_c, old_c;
    logic             do_update;

    always_comb begin
        sq_c      = SQC_W'(r_sq);
        lim_c     = SQC_W'(r_lim);
        old_c     = SQC_W'(ram_rd_data[LIM_W-1:0]);
        do_update = (sq_c < lim_c) && (!ram_rd_data[LIM_W] || (sq_c < old_c));
    end

    // Square root step, two radicand bits per cycle, and final rounding.
    logic [SQRT_STEPS+3:0] sq_cur, sq_trial;
    logic                  sq_ge;
    logic [SQRT_STEPS:0]   root_rnd;
    logic [RANGE_W-1:0]    range_rnd;

    always_comb begin
        sq_cur    = {r_rem, r_rad[2*SQRT_STEPS-1 -: 2]};
        sq_trial  = (SQRT_STEPS+4)'({r_root, 2'b01});
        sq_ge     = sq_cur >= sq_trial;
        root_rnd  = (SQRT_STEPS+1)'(r_root)
                  + (SQRT_STEPS+1)'(r_rem > (SQRT_STEPS+2)'(r_root));
        range_rnd = (root_rnd > (SQRT_STEPS+1)'({RANGE_W{1'b1}}))
                  ? {RANGE_W{1'b1}} : root_rnd[RANGE_W-1:0];
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // The step counter runs only in the looping states.
    logic cnt_run;
    assign cnt_run = (r_state == S_NBIN) || (r_state == S_CORDIC)
                  || (r_state == S_IDX) || (r_state == S_SQRT);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(MAX_BINS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_NBIN;
            end
            S_NBIN: begin
                if (r_cnt == CNT_W'(DIV_W)) begin
                    if (r_op) begin
                        n_state = S_RD_RD;
                    end else if (!r_ok || height_bad) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_CORDIC;
                    end
                end
            end
            S_CORDIC: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS)) begin
                    n_state = angle_bad ? S_RESULT : S_IDX;
                end
            end
            S_IDX: begin
                if (r_cnt == CNT_W'(DIV_W)) n_state = S_RMW_RD;
            end
            S_RMW_RD:  n_state = S_RMW_CMP;
            S_RMW_CMP: n_state = S_RESULT;
            S_RD_RD:   n_state = S_RD_CHK;
            S_RD_CHK:  n_state = rd_has ? S_SQRT : S_RESULT;
            S_SQRT: begin
                if (r_cnt == CNT_W'(SQRT_STEPS)) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs: input stall and bin store ports.
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        ram_we      = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                ram_we      = 1'b1;
                ram_wr_addr = r_clr_addr;
            end
            S_RMW_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_next;
            end
            S_RMW_CMP: begin
                ram_we      = do_update;
                ram_wr_data = {1'b1, LIM_W'(sq_c)};
            end
            S_RD_RD: begin
                ram_rd_en   = sel_in;
                ram_rd_addr = sel_addr;
            end
            S_RD_CHK: begin
                ram_we      = sel_in;
                ram_wr_addr = sel_addr;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Configuration registers and the squared range limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_low   <= 16'sd100;
            r_h_high  <= 16'sd150;
            r_w_start <= -16'sd16384;
            r_w_end   <= 16'sd16384;
            r_bin_w   <= 15'd91;
            r_far     <= 16'd10000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEIGHT_LOW:  r_h_low   <= i_cfg_data;
                CFG_HEIGHT_HIGH: r_h_high  <= i_cfg_data;
                CFG_WIN_START:   r_w_start <= i_cfg_data;
                CFG_WIN_END:     r_w_end   <= i_cfg_data;
                CFG_BIN_WIDTH:   r_bin_w   <= i_cfg_data[WIDTH_W-1:0];
                CFG_FAR_LIMIT:   r_far     <= i_cfg_data;
                default: begin
                end
            endcase
        end
        r_lim <= lim_prod[LIM_W-1:0];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state || !cnt_run) ? '0 : r_cnt + 1'b1;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_op   <= i_operation;
                    r_ok   <= i_point_ok;
                    r_sel  <= i_bin_select;
                    r_y    <= i_coord_y_mm;
                    r_zero <= (i_coord_x_mm == '0) && (i_coord_z_mm == '0);
                    if (i_coord_z_mm[COORD_BITS-1]) begin
                        r_a   <= -z_sc;
                        r_b   <= -x_sc;
                        r_ang <= 32'h8000_0000;
                    end else begin
                        r_a   <= z_sc;
                        r_b   <= x_sc;
                        r_ang <= '0;
                    end
                    r_mx   <= SQ_W'(x_abs);
                    r_mz   <= SQ_W'(z_abs);
                    r_bx   <= x_abs;
                    r_bz   <= z_abs;
                    r_sq   <= '0;
                    r_dq   <= nb_num;
                    r_drem <= '0;
                end
            end
            S_NBIN: begin
                if (r_cnt < CNT_W'(DIV_W)) begin
                    r_drem <= div_rem_n;
                    r_dq   <= {r_dq[DIV_W-2:0], div_ge};
                end else begin
                    r_nbins      <= NB_W'(nb_clamp);
                    r_res_status <= r_ok ? ST_HEIGHT : ST_INVALID;
                    r_res_idx    <= '0;
                    r_res_range  <= '0;
                    r_res_empty  <= 1'b0;
                end
            end
            S_CORDIC: begin
                if (r_cnt < CNT_W'(CORDIC_STEPS)) begin
                    if (b_pos) begin
                        r_a   <= r_a + sh_b;
                        r_b   <= r_b - sh_a;
                        r_ang <= r_ang + atan_v;
                    end else begin
                        r_a   <= r_a - sh_b;
                        r_b   <= r_b + sh_a;
                        r_ang <= r_ang - atan_v;
                    end
                    r_sq <= r_sq + (r_bx[0] ? r_mx : '0) + (r_bz[0] ? r_mz : '0);
                    r_mx <= r_mx << 1;
                    r_mz <= r_mz << 1;
                    r_bx <= r_bx >> 1;
                    r_bz <= r_bz >> 1;
                end else begin
                    r_res_status <= ST_ANGLE;
                    r_dq         <= DIV_W'(ang_diff);
                    r_drem       <= '0;
                end
            end
            S_IDX: begin
                if (r_cnt < CNT_W'(DIV_W)) begin
                    r_drem <= div_rem_n;
                    r_dq   <= {r_dq[DIV_W-2:0], div_ge};
                end
            end
            S_RMW_RD: begin
                r_idx <= idx_next;
            end
            S_RMW_CMP: begin
                r_res_status <= ST_STORED;
                r_res_idx    <= idx_wide[SEL_W-1:0];
            end
            S_RD_CHK: begin
                r_res_status <= ST_READ;
                r_res_idx    <= r_sel;
                r_res_range  <= empty_val;
                r_res_empty  <= 1'b1;
                r_rad        <= (2*SQRT_STEPS)'(ram_rd_data[LIM_W-1:0]);
                r_root       <= '0;
                r_rem        <= '0;
            end
            S_SQRT: begin
                if (r_cnt < CNT_W'(SQRT_STEPS)) begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= sq_ge ? (SQRT_STEPS+2)'(sq_cur - sq_trial)
                                    : (SQRT_STEPS+2)'(sq_cur);
                    r_root <= {r_root[SQRT_STEPS-2:0], sq_ge};
                end else begin
                    r_res_range <= range_rnd;
                    r_res_empty <= 1'b0;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    r_out_status <= r_res_status;
                    r_out_idx    <= r_res_idx;
                    r_out_range  <= r_res_range;
                    r_out_empty  <= r_res_empty;
                end
            end
            default: begin
            end
        endcase
    end

    pcsb_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_BINS)
    ) u_bins (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_bin_index = r_out_idx;
    assign o_range_mm  = r_out_range;
    assign o_bin_empty = r_out_empty;

    `PCSB_ASSERT_NOW(a_rmw_in_window, i_clk, i_rst_n, r_state == S_RMW_CMP,
        DIV_W'(r_idx) < DIV_W'(r_nbins), "bin update outside the bin count")
    `PCSB_ASSERT_NEXT(a_take_blocks, i_clk, i_rst_n, in_take,
        o_in_stall, "second item accepted while one is in work")
    `PCSB_ASSERT_NOW(a_result_source, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_state == S_RESULT), "result appeared without a finished item")
    `PCSB_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= CNT_W'(CORDIC_STEPS), "step counter ran past its longest loop")

endmodule

@@ tb/tb_point_cloud_to_scan_binner.sv @@
// Self-checking testbench for point_cloud_to_scan_binner: directed table, then random
// phases over several register settings. Depends on pcsb_pkg and the block's RTL only.
module tb_point_cloud_to_scan_binner;
    import pcsb_pkg::*;

    // One input item as the sender offers it.
    typedef struct {
        logic               op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               ok;
        logic [8:0]         sel;
    } point_item_t;

    // One result item as the block returns it.
    typedef struct {
        t_status     status;
        logic [8:0]  idx;
        logic [15:0] range;
        logic        empty;
    } scan_result_t;

    // A directed row: the item, and where the answer is obvious, the answer itself.
    typedef struct {
        point_item_t  item;
        bit           typed;
        scan_result_t result;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_operation = 1'b0;
    logic signed [15:0] i_coord_x_mm = '0;
    logic signed [15:0] i_coord_y_mm = '0;
    logic signed [15:0] i_coord_z_mm = '0;
    logic        i_point_ok = 1'b0;
    logic [8:0]  i_bin_select = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [8:0]  o_bin_index;
    logic [15:0] o_range_mm;
    logic        o_bin_empty;

    point_cloud_to_scan_binner u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_coord_x_mm (i_coord_x_mm),
        .i_coord_y_mm (i_coord_y_mm),
        .i_coord_z_mm (i_coord_z_mm),
        .i_point_ok   (i_point_ok),
        .i_bin_select (i_bin_select),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_bin_index  (o_bin_index),
        .o_range_mm   (o_range_mm),
        .o_bin_empty  (o_bin_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the configuration registers and of the bin store.
    logic signed [15:0] height_lo, height_hi, win_start, win_end;
    logic [14:0]        bin_width;
    logic [15:0]        far_limit;
    longint unsigned    bin_range_sq [512];
    bit                 bin_full [512];

    scan_result_t expected_results [$];
    int  mismatch_count = 0;
    int  stored_count = 0;
    int  filled_reads = 0;
    int  result_count = 0;
    bit  quiet = 1'b0;       // no idling on either side in the closing phase
    bit  hold_done = 1'b0;   // the long receiver hold-off has happened

    // Bearing -atan2(x, z) as a 16-bit binary angle, from a 28-step CORDIC that
    // rotates the vector onto the positive z axis.
    function automatic int bearing_of(input longint x, input longint z);
        longint      a, b, na, nb;
        logic [31:0] ang, neg, r;
        logic [15:0] r16;
        if (x == 0 && z == 0) return 0;
        a = z * 65536;
        b = x * 65536;
        ang = '0;
        if (a < 0) begin
            a = -a;
            b = -b;
            ang = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (b > 0) begin
                na = a + (b >>> i);
                nb = b - (a >>> i);
                ang = ang + atan_entry(i[4:0]);
            end else begin
                na = a - (b >>> i);
                nb = b + (a >>> i);
                ang = ang - atan_entry(i[4:0]);
            end
            a = na;
            b = nb;
        end
        neg = 32'd0 - ang;
        r = (neg + 32'h00008000) >> 16;
        r16 = r[15:0];
        return int'($signed(r16));
    endfunction

    function automatic int bins_in_window();
        int span, w, n;
        span = int'(win_end) - int'(win_start);
        w = (bin_width == 0) ? 1 : int'(bin_width);
        n = (span <= 0) ? 1 : (span + w - 1) / w;
        if (n < 1) n = 1;
        if (n > 512) n = 512;
        return n;
    endfunction

    // Square root rounded to nearest, saturated to 16 bits.
    function automatic logic [15:0] rounded_root(input longint unsigned s);
        longint unsigned v, r, b;
        v = s;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s - r * r > r) r++;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    // Works out the result of one accepted item and updates the mirrored store.
    function automatic scan_result_t bin_point(input point_item_t it);
        scan_result_t    res;
        int              nbins, ang, w;
        longint          xx, zz;
        longint unsigned sq, lim, empty_val;
        int unsigned     idx;
        res = '{ST_STORED, 9'd0, 16'd0, 1'b0};
        nbins = bins_in_window();
        empty_val = longint'(far_limit) + 1000;
        if (empty_val > 65535) empty_val = 65535;
        if (it.op) begin
            res.status = ST_READ;
            res.idx = it.sel;
            res.range = empty_val[15:0];
            res.empty = 1'b1;
            if (int'(it.sel) < nbins && bin_full[it.sel]) begin
                res.range = rounded_root(bin_range_sq[it.sel]);
                res.empty = 1'b0;
                filled_reads++;
            end
            bin_full[it.sel] = 1'b0;
            return res;
        end
        if (!it.ok) begin
            res.status = ST_INVALID;
            return res;
        end
        if (it.y > height_hi || it.y < height_lo) begin
            res.status = ST_HEIGHT;
            return res;
        end
        ang = bearing_of(it.x, it.z);
        if (ang < int'(win_start) || ang > int'(win_end)) begin
            res.status = ST_ANGLE;
            return res;
        end
        w = (bin_width == 0) ? 1 : int'(bin_width);
        idx = (ang - int'(win_start)) / w;
        if (idx >= nbins) idx = nbins - 1;
        xx = it.x;
        zz = it.z;
        sq = xx * xx + zz * zz;
        lim = (longint'(far_limit) + 1000) * (longint'(far_limit) + 1000);
        // Far points still report their bin but leave it untouched.
        if (sq < lim && (!bin_full[idx] || sq < bin_range_sq[idx])) begin
            bin_range_sq[idx] = sq;
            bin_full[idx] = 1'b1;
        end
        stored_count++;
        res.idx = idx[8:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Result checker: every output transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        scan_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                if (o_bin_index !== want.idx)
                    report_mismatch($sformatf("bin_index %0d, expected %0d",
                                              o_bin_index, want.idx));
                if (o_range_mm !== want.range)
                    report_mismatch($sformatf("range_mm %0d, expected %0d",
                                              o_range_mm, want.range));
                if (o_bin_empty !== want.empty)
                    report_mismatch($sformatf("bin_empty %0d, expected %0d",
                                              o_bin_empty, want.empty));
            end
        end
    end

    // Receiver: random stall bursts. Once, some way into the run, it holds
    // off for a long stretch so that the block backs up and stalls its input
    // while the sender keeps offering items.
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(negedge i_clk);
            cycles++;
            if (!hold_done && cycles == 40000) begin
                i_out_stall = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_done = 1'b1;
                i_out_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 3) - 1) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // Offers one item from a falling edge and returns at a falling edge after
    // its transfer. The prediction is taken at the transfer itself.
    task automatic send_item(input point_item_t it, input bit typed,
                             input scan_result_t typed_result);
        scan_result_t predicted;
        i_operation  = it.op;
        i_coord_x_mm = it.x;
        i_coord_y_mm = it.y;
        i_coord_z_mm = it.z;
        i_point_ok   = it.ok;
        i_bin_select = it.sel;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = bin_point(it);
        if (typed && (predicted.status != typed_result.status
                      || predicted.idx != typed_result.idx
                      || predicted.range != typed_result.range
                      || predicted.empty != typed_result.empty))
            report_mismatch("directed row disagrees with the predictor");
        expected_results.push_back(typed ? typed_result : predicted);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    // Waits until every result is back, then lets the block settle so that
    // register writes land while it is idle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_settings(input logic signed [15:0] lo, input logic signed [15:0] hi,
                                  input logic signed [15:0] ws, input logic signed [15:0] we,
                                  input logic [14:0] bw, input logic [15:0] far);
        logic [15:0] vals [6];
        vals = '{lo, hi, ws, we, {1'b0, bw}, far};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    = 1'b1;
            i_cfg_index = i[2:0];
            i_cfg_data  = vals[i];
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        height_lo = lo;
        height_hi = hi;
        win_start = ws;
        win_end   = we;
        bin_width = bw;
        far_limit = far;
    endtask

    // Coordinates of mixed magnitude: mostly near the sensor, sometimes anywhere.
    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($signed($urandom_range(0, 12000)) - 6000);
        endcase
    endfunction

    // Mostly well-formed adds at a height inside the band, reads of live bins,
    // and some noise: invalid points, heights anywhere, reads past the window.
    function automatic point_item_t random_item();
        point_item_t it;
        int nbins;
        nbins = bins_in_window();
        it.op  = ($urandom_range(0, 4) == 0);
        it.x   = random_coord();
        it.z   = random_coord();
        it.ok  = ($urandom_range(0, 19) != 0);
        it.sel = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, nbins - 1));
        if (height_lo <= height_hi && $urandom_range(0, 9) != 0)
            it.y = 16'($urandom_range(0, int'(height_hi) - int'(height_lo)) + int'(height_lo));
        else
            it.y = 16'($urandom);
        return it;
    endfunction

    dir_row_t dir_rows [20];

    initial begin
        scan_result_t none;
        none = '{ST_STORED, 9'd0, 16'd0, 1'b0};
        // Reset settings: heights 100..150, window of +/- a quarter turn,
        // bins 91 wide (361 bins), far limit 10 m, so an empty bin reads 11000.
        dir_rows = '{
            '{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 9'd0}, 1'b1,
              '{ST_READ, 9'd0, 16'd11000, 1'b1}},
            '{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 9'd511}, 1'b1,
              '{ST_READ, 9'd511, 16'd11000, 1'b1}},
            '{'{1'b0, 16'sd1, 16'sd120, 16'sd1000, 1'b0, 9'd0}, 1'b1,
              '{ST_INVALID, 9'd0, 16'd0, 1'b0}},
            '{'{1'b0, 16'sd1, -16'sd32768, 16'sd1000, 1'b1, 9'd0}, 1'b1,
              '{ST_HEIGHT, 9'd0, 16'd0, 1'b0}},
            '{'{1'b0, 16'sd1, 16'sd32767, 16'sd1000, 1'b1, 9'd0}, 1'b1,
              '{ST_HEIGHT, 9'd0, 16'd0, 1'b0}},
            '{'{1'b0, 16'sd0, 16'sd99, 16'sd1000, 1'b1, 9'd0}, 1'b1,
              '{ST_HEIGHT, 9'd0, 16'd0, 1'b0}},
            // Straight behind the sensor: the bearing is a half turn.
            '{'{1'b0, 16'sd0, 16'sd120, -16'sd1000, 1'b1, 9'd0}, 1'b1,
              '{ST_ANGLE, 9'd0, 16'd0, 1'b0}},
            '{'{1'b0, 16'sd0, 16'sd100, 16'sd0, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b0, 16'sd32767, 16'sd150, 16'sd32767, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b0, -16'sd32768, 16'sd120, 16'sd32767, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b0, -16'sd1000, 16'sd120, 16'sd0, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b0, 16'sd1000, 16'sd120, 16'sd0, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b0, 16'sd300, 16'sd120, 16'sd4000, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b0, 16'sd300, 16'sd120, 16'sd3000, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b0, 16'sd0, 16'sd120, 16'sd20000, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b0, 16'sd0, 16'sd120, -16'sd32768, 1'b1, 9'd0}, 1'b0, none},
            '{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 9'd180}, 1'b0, none},
            '{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 9'd170}, 1'b0, none},
            '{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 9'd360}, 1'b0, none},
            '{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 9'd180}, 1'b1,
              '{ST_READ, 9'd180, 16'd11000, 1'b1}}
        };
    end

    // Main sequence.
    initial begin
        height_lo = 16'sd100;
        height_hi = 16'sd150;
        win_start = -16'sd16384;
        win_end   = 16'sd16384;
        bin_width = 15'd91;
        far_limit = 16'd10000;
        for (int i = 0; i < 512; i++) bin_full[i] = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].result);
        drain();

        // Random phases: each writes every register, then runs about 250 items.
        // The settings cover the full window with one-unit bins (clamped to the
        // store size, the index clamp acting at the window end), zero bin width,
        // an inverted window with a single bin, and far limits of 0 and 45000.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_settings(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                                  15'd1, 16'd45000);
                1: write_settings(-16'sd500, 16'sd500, -16'sd16384, 16'sd16384,
                                  15'd91, 16'd10000);
                2: write_settings(16'sd0, 16'sd2000, -16'sd100, 16'sd100, 15'd0, 16'd0);
                3: write_settings(-16'sd200, 16'sd200, 16'sd8000, -16'sd8000,
                                  15'd64, 16'd3000);
                4: write_settings(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                                  15'd32767, 16'd45000);
                5: write_settings(-16'sd1000, 16'sd1000, -16'sd30000, 16'sd29000,
                                  15'd150, 16'd20000);
                default: begin
                    quiet = 1'b1;
                    write_settings(-16'sd32768, 16'sd32767, -16'sd20000, 16'sd20000,
                                   15'd777, 16'd5000);
                end
            endcase
            repeat (250) send_item(random_item(), 1'b0, '{ST_STORED, 9'd0, 16'd0, 1'b0});
            drain();
        end

        $display("Covered %0d results over seven register settings: %0d points binned,",
                 result_count, stored_count);
        $display("%0d reads of filled bins, rejects, far points and a long output hold-off.",
                 filled_reads);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #30000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
